/* src/tsb_pkg.sv */
package tsb_pkg;

  localparam int TEXEL_COUNT = 65536;
  localparam int ADDR_W      = $clog2(TEXEL_COUNT);

  localparam int SIZE_W      = 9;
  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = COORD_W + SIZE_W;
  localparam int IDX_W       = 2 * SIZE_W;
  localparam int CHAN_W      = 8;
  localparam int TEXEL_W     = 3 * CHAN_W;
  localparam int LUM_W       = 16;
  localparam int LEVEL_W     = LUM_W - 1;
  localparam int BLEND_W     = FRAC_W + 1;
  localparam int HSUM_W      = FRAC_W + CHAN_W;
  localparam int VSUM_W      = 2 * FRAC_W + CHAN_W;
  localparam int PROD_W      = VSUM_W + LEVEL_W;
  localparam int OUT_SHIFT   = 2 * FRAC_W + 12;
  localparam int CLAMP_W     = PROD_W - OUT_SHIFT;
  localparam int CHAN_MAX    = 255;
  localparam int LUM_ONE     = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = SIZE_W;

  localparam int CORNER_TL   = 0;
  localparam int CORNER_TR   = 1;
  localparam int CORNER_BL   = 2;
  localparam int CORNER_BR   = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_MODE    = 3'd0,
    REG_TEXTURE_WIDTH  = 3'd1,
    REG_TEXTURE_HEIGHT = 3'd2,
    REG_ATLAS_ENABLE   = 3'd3,
    REG_TILE_SIZE      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              filter_mode;
    logic [SIZE_W-1:0] texture_width;
    logic [SIZE_W-1:0] texture_height;
    logic              atlas_enable;
    logic [SIZE_W-1:0] tile_size;
  } cfg_t;

  typedef struct packed {
    op_t                      op;
    logic [15:0]              texel_address;
    logic [TEXEL_W-1:0]       texel_rgb;
    logic [COORD_W-1:0]       coord_u;
    logic [COORD_W-1:0]       coord_v;
    logic signed [LUM_W-1:0]  brightness;
  } in_item_t;

  typedef struct packed {
    op_t                        op;
    logic [3:0][ADDR_W-1:0]     addr;
    logic [TEXEL_W-1:0]         texel_rgb;
    logic [FRAC_W-1:0]          frac_u;
    logic [FRAC_W-1:0]          frac_v;
    logic [LEVEL_W-1:0]         level;
  } fetch_item_t;

endpackage

/* src/tsb_ram.sv */
module tsb_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* src/tsb_addr.sv */
module tsb_addr import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output fetch_item_t out_item
);

  function automatic logic [SIZE_W-1:0] size_or_one(input logic [SIZE_W-1:0] s);
    size_or_one = (s == '0) ? SIZE_W'(1) : s;
  endfunction

  // one restoring step of pos mod t
  function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
                                                 input logic b,
                                                 input logic [SIZE_W-1:0] t);
    logic [SIZE_W:0] s;
    s = {r, b};
    if (s >= {1'b0, t}) begin
      rem_step = SIZE_W'(s - {1'b0, t});
    end else begin
      rem_step = s[SIZE_W-1:0];
    end
  endfunction

  // next column or row, wrapped in the tile and then in the texture
  function automatic logic [SIZE_W-1:0] next_pos(input logic [SIZE_W-1:0] pos,
                                                 input logic [SIZE_W-1:0] rem,
                                                 input logic [SIZE_W-1:0] t,
                                                 input logic atlas,
                                                 input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    if (atlas && rem == t - SIZE_W'(1)) begin
      n = pos - rem;
    end else begin
      n = pos + SIZE_W'(1);
    end
    if (n == size) begin
      n = '0;
    end
    next_pos = n;
  endfunction

  logic [SIZE_W-1:0] w_eff, h_eff, t_eff;

  assign w_eff = size_or_one(cfg.texture_width);
  assign h_eff = size_or_one(cfg.texture_height);
  assign t_eff = size_or_one(cfg.tile_size);

  logic en1, en2, en3, en4, en5, en6;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: scale coordinates
  op_t                     op1;
  logic [15:0]             taddr1;
  logic [TEXEL_W-1:0]      rgb1;
  logic signed [LUM_W-1:0] lum1;
  logic [POS_W-1:0]        tx1, ty1;

  // stages 2..4: tile remainder, three bits per stage
  op_t                op2, op3, op4;
  logic [15:0]        taddr2, taddr3, taddr4;
  logic [TEXEL_W-1:0] rgb2, rgb3, rgb4;
  logic [LEVEL_W-1:0] lvl2, lvl3, lvl4;
  logic [FRAC_W-1:0]  fu2, fu3, fu4, fv2, fv3, fv4;
  logic [SIZE_W-1:0]  left2, left3, left4, top2, top3, top4;
  logic [SIZE_W-1:0]  reml2, reml3, reml4, remt2, remt3, remt4;

  // stage 5: neighbors
  op_t                op5;
  logic [15:0]        taddr5;
  logic [TEXEL_W-1:0] rgb5;
  logic [LEVEL_W-1:0] lvl5;
  logic [FRAC_W-1:0]  fu5, fv5;
  logic [SIZE_W-1:0]  left5, top5, right5, bottom5;

  // stage 6: texel indexes
  fetch_item_t item6;

  assign en6 = !v6 || out_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  logic [LEVEL_W-1:0] lvl1_eff;
  logic [SIZE_W-1:0]  left1, top1;
  logic [SIZE_W-1:0]  reml1_s, remt1_s, reml3_s, remt3_s, reml4_s, remt4_s;
  logic [IDX_W-1:0]   topw5, botw5;

  always_comb begin
    if (cfg.filter_mode) begin
      lvl1_eff = (lum1 > 0) ? lum1[LEVEL_W-1:0] : '0;
    end else begin
      lvl1_eff = (lum1 > LUM_W'(LUM_ONE)) ? lum1[LEVEL_W-1:0] : LEVEL_W'(LUM_ONE);
    end
    left1   = tx1[POS_W-1:FRAC_W];
    top1    = ty1[POS_W-1:FRAC_W];
    reml1_s = rem_step(rem_step(rem_step('0, left1[8], t_eff), left1[7], t_eff),
                       left1[6], t_eff);
    remt1_s = rem_step(rem_step(rem_step('0, top1[8], t_eff), top1[7], t_eff),
                       top1[6], t_eff);
    reml3_s = rem_step(rem_step(rem_step(reml2, left2[5], t_eff), left2[4], t_eff),
                       left2[3], t_eff);
    remt3_s = rem_step(rem_step(rem_step(remt2, top2[5], t_eff), top2[4], t_eff),
                       top2[3], t_eff);
    reml4_s = rem_step(rem_step(rem_step(reml3, left3[2], t_eff), left3[1], t_eff),
                       left3[0], t_eff);
    remt4_s = rem_step(rem_step(rem_step(remt3, top3[2], t_eff), top3[1], t_eff),
                       top3[0], t_eff);
    topw5   = IDX_W'(top5) * IDX_W'(w_eff);
    botw5   = IDX_W'(bottom5) * IDX_W'(w_eff);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1    <= in_item.op;
      taddr1 <= in_item.texel_address;
      rgb1   <= in_item.texel_rgb;
      lum1   <= in_item.brightness;
      tx1    <= POS_W'(in_item.coord_u) * POS_W'(w_eff);
      ty1    <= POS_W'(in_item.coord_v) * POS_W'(h_eff);
    end
    if (en2) begin
      op2    <= op1;
      taddr2 <= taddr1;
      rgb2   <= rgb1;
      lvl2   <= lvl1_eff;
      // nearest reads the top-left texel at full weight
      fu2    <= cfg.filter_mode ? tx1[FRAC_W-1:0] : '0;
      fv2    <= cfg.filter_mode ? ty1[FRAC_W-1:0] : '0;
      left2  <= left1;
      top2   <= top1;
      reml2  <= reml1_s;
      remt2  <= remt1_s;
    end
    if (en3) begin
      op3    <= op2;
      taddr3 <= taddr2;
      rgb3   <= rgb2;
      lvl3   <= lvl2;
      fu3    <= fu2;
      fv3    <= fv2;
      left3  <= left2;
      top3   <= top2;
      reml3  <= reml3_s;
      remt3  <= remt3_s;
    end
    if (en4) begin
      op4    <= op3;
      taddr4 <= taddr3;
      rgb4   <= rgb3;
      lvl4   <= lvl3;
      fu4    <= fu3;
      fv4    <= fv3;
      left4  <= left3;
      top4   <= top3;
      reml4  <= reml4_s;
      remt4  <= remt4_s;
    end
    if (en5) begin
      op5     <= op4;
      taddr5  <= taddr4;
      rgb5    <= rgb4;
      lvl5    <= lvl4;
      fu5     <= fu4;
      fv5     <= fv4;
      left5   <= left4;
      top5    <= top4;
      // nearest touches only the top-left texel, so park every corner on it
      right5  <= cfg.filter_mode ? next_pos(left4, reml4, t_eff, cfg.atlas_enable, w_eff)
                                 : left4;
      bottom5 <= cfg.filter_mode ? next_pos(top4, remt4, t_eff, cfg.atlas_enable, h_eff)
                                 : top4;
    end
    if (en6) begin
      item6.op        <= op5;
      item6.texel_rgb <= rgb5;
      item6.frac_u    <= fu5;
      item6.frac_v    <= fv5;
      item6.level     <= lvl5;
      if (op5 == OP_WRITE) begin
        item6.addr[CORNER_TL] <= taddr5[ADDR_W-1:0];
      end else begin
        item6.addr[CORNER_TL] <= ADDR_W'(topw5 + IDX_W'(left5));
      end
      item6.addr[CORNER_TR] <= ADDR_W'(topw5 + IDX_W'(right5));
      item6.addr[CORNER_BL] <= ADDR_W'(botw5 + IDX_W'(left5));
      item6.addr[CORNER_BR] <= ADDR_W'(botw5 + IDX_W'(right5));
    end
  end

  assign out_valid = v6;
  assign out_item  = item6;

endmodule

/* src/tsb_filter.sv */
module tsb_filter import tsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fetch_item_t           in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0][CHAN_W-1:0] out_rgb
);

  logic en7, en8, en9, en10;
  logic v7, v8, v9, v10;
  logic we;

  logic [TEXEL_W-1:0] tl7, tr7, bl7, br7;
  logic [FRAC_W-1:0]  fu7, fv7, fv8;
  logic [LEVEL_W-1:0] lvl7, lvl8, lvl9;

  logic [2:0][HSUM_W-1:0] hsum_top8, hsum_bot8;
  logic [2:0][VSUM_W-1:0] vsum9;
  logic [2:0][CHAN_W-1:0] rgb10;

  assign en10 = !v10 || out_ready;
  assign en9  = !v9 || en10;
  assign en8  = !v8 || en9;
  assign en7  = !v7 || en8;
  assign in_ready = en7;

  // commit a texel write in the same stage that samples read
  assign we = en7 && in_valid && (in_item.op == OP_WRITE);

  tsb_ram #(.ADDR_W(ADDR_W), .DATA_W(TEXEL_W)) u_ram_top (
    .clk    (clk),
    .we     (we),
    .waddr  (in_item.addr[CORNER_TL]),
    .wdata  (in_item.texel_rgb),
    .re     (en7),
    .raddr0 (in_item.addr[CORNER_TL]),
    .raddr1 (in_item.addr[CORNER_TR]),
    .rdata0 (tl7),
    .rdata1 (tr7)
  );

  tsb_ram #(.ADDR_W(ADDR_W), .DATA_W(TEXEL_W)) u_ram_bot (
    .clk    (clk),
    .we     (we),
    .waddr  (in_item.addr[CORNER_TL]),
    .wdata  (in_item.texel_rgb),
    .re     (en7),
    .raddr0 (in_item.addr[CORNER_BL]),
    .raddr1 (in_item.addr[CORNER_BR]),
    .rdata0 (bl7),
    .rdata1 (br7)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (en7)  v7  <= in_valid && (in_item.op == OP_SAMPLE);
      if (en8)  v8  <= v7;
      if (en9)  v9  <= v8;
      if (en10) v10 <= v9;
    end
  end

  logic [BLEND_W-1:0]     wl7, wt8;
  logic [2:0][HSUM_W-1:0] hsum_top7, hsum_bot7;
  logic [2:0][VSUM_W-1:0] vsum8;
  logic [2:0][CHAN_W-1:0] rgb9;
  logic [2:0][PROD_W-1:0] prod9;

  always_comb begin
    wl7 = BLEND_W'(1 << FRAC_W) - BLEND_W'(fu7);
    wt8 = BLEND_W'(1 << FRAC_W) - BLEND_W'(fv8);
    for (int k = 0; k < 3; k++) begin
      hsum_top7[k] = HSUM_W'(
          (HSUM_W + 1)'(wl7) * (HSUM_W + 1)'(tl7[TEXEL_W-1-CHAN_W*k -: CHAN_W])
        + (HSUM_W + 1)'(fu7) * (HSUM_W + 1)'(tr7[TEXEL_W-1-CHAN_W*k -: CHAN_W]));
      hsum_bot7[k] = HSUM_W'(
          (HSUM_W + 1)'(wl7) * (HSUM_W + 1)'(bl7[TEXEL_W-1-CHAN_W*k -: CHAN_W])
        + (HSUM_W + 1)'(fu7) * (HSUM_W + 1)'(br7[TEXEL_W-1-CHAN_W*k -: CHAN_W]));
      vsum8[k] = VSUM_W'(
          (VSUM_W + 1)'(wt8) * (VSUM_W + 1)'(hsum_top8[k])
        + (VSUM_W + 1)'(fv8) * (VSUM_W + 1)'(hsum_bot8[k]));
      prod9[k] = PROD_W'(vsum9[k]) * PROD_W'(lvl9);
      // truncate, then saturate
      if (prod9[k][PROD_W-1:OUT_SHIFT] > CLAMP_W'(CHAN_MAX)) begin
        rgb9[k] = CHAN_W'(CHAN_MAX);
      end else begin
        rgb9[k] = prod9[k][OUT_SHIFT+CHAN_W-1:OUT_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      fu7  <= in_item.frac_u;
      fv7  <= in_item.frac_v;
      lvl7 <= in_item.level;
    end
    if (en8) begin
      fv8       <= fv7;
      lvl8      <= lvl7;
      hsum_top8 <= hsum_top7;
      hsum_bot8 <= hsum_bot7;
    end
    if (en9) begin
      lvl9  <= lvl8;
      vsum9 <= vsum8;
    end
    if (en10) begin
      rgb10 <= rgb9;
    end
  end

  assign out_valid = v10;
  assign out_rgb   = rgb10;

endmodule

/* src/texture_sampler_bilinear.sv */
// Texture sampler: a 65536-entry RGB texel memory with nearest or bilinear lookup.
// Input words arrive on s_tvalid/s_tready/s_tdata with s_tuser selecting the
// operation: 0 stores texel_rgb at texel_address and yields no result, 1 samples
// the texture at (coord_u, coord_v) scaled by brightness and yields one word on
// m_tvalid/m_tready/m_tdata. Registers are written through cfg_valid/cfg_index/
// cfg_data, one per cycle; cfg_ready is always high. Write them only while idle.
// A sample word accepted by the block raises m_tvalid through ten register stages,
// the first loaded at the accepting edge: six stages form coordinates, the tile
// remainder (three bits a stage), neighbors and texel indexes; then one memory
// read stage, two blend stages and a brightness stage.
// Throughput is one word per cycle while m_tready is high, set by the two dual-read
// texel memory copies that deliver all four neighbors from one read.
// A texel write commits in the memory stage, in order with the samples around it.
// Reset clears every stage valid bit and loads the register defaults; the texel
// memory is not cleared, and samples must only hit texels already written.
// When m_tready is low each stage holds while bubbles ahead of it close up, so
// s_tready stays high until the pipeline is full; nothing is lost or repeated.
module texture_sampler_bilinear import tsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // texel_address[15:0], texel_rgb[39:16], coord_u[55:40], coord_v[71:56],
  // brightness[87:72]
  input  logic [87:0]            s_tdata,
  // operation[0]
  input  logic                   s_tuser,
  // result words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0]            m_tdata
);

  cfg_t cfg;

  // accept every register write; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode    <= 1'b1;
      cfg.texture_width  <= SIZE_W'(256);
      cfg.texture_height <= SIZE_W'(256);
      cfg.atlas_enable   <= 1'b0;
      cfg.tile_size      <= SIZE_W'(16);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_MODE:    cfg.filter_mode    <= cfg_data[0];
        REG_TEXTURE_WIDTH:  cfg.texture_width  <= cfg_data;
        REG_TEXTURE_HEIGHT: cfg.texture_height <= cfg_data;
        REG_ATLAS_ENABLE:   cfg.atlas_enable   <= cfg_data[0];
        REG_TILE_SIZE:      cfg.tile_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input word
  in_item_t in_item;

  assign in_item.op            = op_t'(s_tuser);
  assign in_item.texel_address = s_tdata[15:0];
  assign in_item.texel_rgb     = s_tdata[39:16];
  assign in_item.coord_u       = s_tdata[55:40];
  assign in_item.coord_v       = s_tdata[71:56];
  assign in_item.brightness    = s_tdata[87:72];

  logic                   fetch_valid;
  logic                   fetch_ready;
  fetch_item_t            fetch_item;
  logic [2:0][CHAN_W-1:0] out_rgb;

  // coordinate, neighbor and index stages
  tsb_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (fetch_valid),
    .out_ready (fetch_ready),
    .out_item  (fetch_item)
  );

  // texel memory, blend and brightness stages
  tsb_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fetch_valid),
    .in_ready  (fetch_ready),
    .in_item   (fetch_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rgb   (out_rgb)
  );

  // red sits in the lowest byte
  assign m_tdata = {out_rgb[2], out_rgb[1], out_rgb[0]};

endmodule
